// ----- sv/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg: shared types, constants and symbol lookup for the Morse keyer
// Holds the ITU symbol tables, register codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package mck_pkg;

    localparam int CHAR_W    = 8;
    localparam int UNIT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ELEM_W    = 5;
    localparam int CNT_W     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DASH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP   = 2'd2;

    localparam logic [UNIT_W-1:0] DASH_RST       = 4'd3;
    localparam logic [UNIT_W-1:0] LETTER_GAP_RST = 4'd2;
    localparam logic [UNIT_W-1:0] WORD_GAP_RST   = 4'd6;
    localparam logic [UNIT_W-1:0] ONE_UNIT       = 4'd1;

    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

    localparam logic [CNT_W-1:0] SYM_LEN_MAX = 3'd5;

    // Symbol code: [7:5] element count, [4:0] elements, first in bit (count-1),
    // 1 = dash, 0 = dot.
    localparam logic [7:0] LETTER_SYMS [26] = '{
        {3'd2, 5'h01}, {3'd4, 5'h08}, {3'd4, 5'h0A}, {3'd3, 5'h04},
        {3'd1, 5'h00}, {3'd4, 5'h02}, {3'd3, 5'h06}, {3'd4, 5'h00},
        {3'd2, 5'h00}, {3'd4, 5'h07}, {3'd3, 5'h05}, {3'd4, 5'h04},
        {3'd2, 5'h03}, {3'd2, 5'h02}, {3'd3, 5'h07}, {3'd4, 5'h06},
        {3'd4, 5'h0D}, {3'd3, 5'h02}, {3'd3, 5'h00}, {3'd1, 5'h01},
        {3'd3, 5'h01}, {3'd4, 5'h01}, {3'd3, 5'h03}, {3'd4, 5'h09},
        {3'd4, 5'h0B}, {3'd4, 5'h0C}
    };

    localparam logic [7:0] DIGIT_SYMS [10] = '{
        {3'd5, 5'h1F}, {3'd5, 5'h0F}, {3'd5, 5'h07}, {3'd5, 5'h03},
        {3'd5, 5'h01}, {3'd5, 5'h00}, {3'd5, 5'h10}, {3'd5, 5'h18},
        {3'd5, 5'h1C}, {3'd5, 5'h1E}
    };

    typedef struct packed {
        logic              known;
        logic [CNT_W-1:0]  count;
        logic [ELEM_W-1:0] elems;   // first element in the MSB
    } sym_t;

    typedef struct packed {
        logic load;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic next_last;
    } stat_t;

    function automatic sym_t sym_lookup(input logic [CHAR_W-1:0] c);
        sym_t              s;
        logic [7:0]        code;
        logic [CHAR_W-1:0] off;
        code = 8'h00;
        off  = '0;
        s.known = 1'b0;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            off     = c - ASCII_UPPER_A;
            code    = LETTER_SYMS[off[4:0]];
            s.known = 1'b1;
        end
        else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            off     = c - ASCII_LOWER_A;
            code    = LETTER_SYMS[off[4:0]];
            s.known = 1'b1;
        end
        else if (c >= ASCII_DIGIT_0 && c <= ASCII_DIGIT_9) begin
            off     = c - ASCII_DIGIT_0;
            code    = DIGIT_SYMS[off[3:0]];
            s.known = 1'b1;
        end
        s.count = s.known ? code[7:5] : '0;
        s.elems = ELEM_W'(code[4:0] << (SYM_LEN_MAX - code[7:5]));
        return s;
    endfunction

endpackage

// ----- sv/mck_if.sv -----
// ----------------------------------------------------------------------------
// mck_if: valid/ready channels of the Morse keyer
// Character input channel and lamp segment output channel.
// ----------------------------------------------------------------------------
interface mck_char_if;
    logic                      valid;
    logic                      ready;
    logic [mck_pkg::CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface mck_seg_if;
    logic                      valid;
    logic                      ready;
    logic                      lamp_on;
    logic [mck_pkg::UNIT_W-1:0] duration_units;
    logic                      last_segment;

    modport source (output valid, output lamp_on, output duration_units,
                    output last_segment, input ready);
    modport sink   (input valid, input lamp_on, input duration_units,
                    input last_segment, output ready);
endinterface

// ----- sv/mck_ctrl.sv -----
// ----------------------------------------------------------------------------
// mck_ctrl: keyer controller
// Takes one character, then steps the datapath through its segments.
// ----------------------------------------------------------------------------
module mck_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mck_pkg::stat_t stat,
    output mck_pkg::cmd_t  cmd
);
    import mck_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.load = in_valid && in_ready;
    assign cmd.emit = (state_reg == ST_RUN) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && stat.next_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/mck_datapath.sv -----
// ----------------------------------------------------------------------------
// mck_datapath: keyer datapath
// Timing registers, symbol lookup, element shifter and output segment register.
// ----------------------------------------------------------------------------
module mck_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mck_pkg::UNIT_W-1:0]        cfg_wdata,
    input  logic [mck_pkg::CHAR_W-1:0]        character,
    input  logic                              out_ready,
    input  mck_pkg::cmd_t                     cmd,
    output mck_pkg::stat_t                    stat,
    output logic                              out_valid,
    output logic                              lamp_on,
    output logic [mck_pkg::UNIT_W-1:0]        duration_units,
    output logic                              last_segment
);
    import mck_pkg::*;

    logic [UNIT_W-1:0] dash_reg;
    logic [UNIT_W-1:0] lgap_reg;
    logic [UNIT_W-1:0] wgap_reg;

    logic              space_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ELEM_W-1:0] elems_reg;
    logic              gap_phase_reg;   // 1: off slot after the current element

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              lamp_reg;
    logic [UNIT_W-1:0] dur_reg;
    logic              last_reg;

    logic              seg_lamp;
    logic [UNIT_W-1:0] seg_dur;
    logic              seg_last;
    logic              in_elems;
    sym_t              sym;

    assign sym      = sym_lookup(character);
    assign in_elems = !space_reg && (cnt_reg != '0);

    always_comb
    begin
        seg_lamp = 1'b0;
        seg_dur  = lgap_reg;
        seg_last = 1'b1;
        if (space_reg)
        begin
            seg_dur = wgap_reg;
        end
        else if (in_elems && !gap_phase_reg)
        begin
            seg_lamp = 1'b1;
            seg_dur  = elems_reg[ELEM_W-1] ? dash_reg : ONE_UNIT;
            seg_last = 1'b0;
        end
        else if (in_elems)
        begin
            seg_dur  = ONE_UNIT;
            seg_last = 1'b0;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.next_last = seg_last;

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_reg      <= DASH_RST;
            lgap_reg      <= LETTER_GAP_RST;
            wgap_reg      <= WORD_GAP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DASH:       dash_reg <= cfg_wdata;
                    REG_LETTER_GAP: lgap_reg <= cfg_wdata;
                    REG_WORD_GAP:   wgap_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            space_reg     <= (character == ASCII_SPACE);
            cnt_reg       <= sym.count;
            elems_reg     <= sym.elems;
            gap_phase_reg <= 1'b0;
        end
        else if (cmd.emit && in_elems)
        begin
            if (gap_phase_reg)
            begin
                cnt_reg       <= cnt_reg - 1'b1;
                elems_reg     <= {elems_reg[ELEM_W-2:0], 1'b0};
                gap_phase_reg <= 1'b0;
            end
            else
            begin
                gap_phase_reg <= 1'b1;
            end
        end
        if (cmd.emit)
        begin
            lamp_reg <= seg_lamp;
            dur_reg  <= seg_dur;
            last_reg <= seg_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lamp_on        = lamp_reg;
    assign duration_units = dur_reg;
    assign last_segment   = last_reg;

endmodule

// ----- sv/morse_code_keyer_core.sv -----
// ----------------------------------------------------------------------------
// morse_code_keyer_core: ITU Morse keyer, letters and digits
// Turns one ASCII character into a run of timed lamp segments.
// ----------------------------------------------------------------------------
// Each accepted character produces 1 to 11 segments (lamp level plus a length
// in time units); the final one carries last_segment. Once a character is
// loaded, the segment sequencer emits one segment per cycle while the output
// is not stalled, and the next character is taken once the last segment sits
// in the output register. Letters in either case and digits follow the ITU
// table, a space gives a single word-gap segment, any other code gives only
// the letter gap. Timing registers (0 dash, 1 letter gap, 2 word gap) are to
// be written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module morse_code_keyer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    mck_char_if.sink                      in_ch,
    mck_seg_if.source                     out_seg,
    input  logic                          cfg_we,
    input  logic [mck_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mck_pkg::UNIT_W-1:0]    cfg_wdata
);
    import mck_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mck_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mck_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .character      (in_ch.character),
        .out_ready      (out_seg.ready),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_seg.valid),
        .lamp_on        (out_seg.lamp_on),
        .duration_units (out_seg.duration_units),
        .last_segment   (out_seg.last_segment)
    );

endmodule

// ----- sv/mck_checker.sv -----
// ----------------------------------------------------------------------------
// mck_checker: port-level checks for the Morse keyer
// Watches both channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module mck_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       lamp_on,
    input  logic [mck_pkg::UNIT_W-1:0] duration_units,
    input  logic                       last_segment
);
    import mck_pkg::*;

    // a character busies the input side once it is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transaction");

    a_busy_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without a transaction");

    // a lit segment is always followed by its off slot
    a_lit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lamp_on |-> !last_segment)
        else $error("lamp-on segment flagged last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(lamp_on) && $stable(duration_units) && $stable(last_segment))
        else $error("output payload changed while stalled");

endmodule

bind morse_code_keyer_core mck_checker u_mck_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_seg.valid),
    .out_ready      (out_seg.ready),
    .lamp_on        (out_seg.lamp_on),
    .duration_units (out_seg.duration_units),
    .last_segment   (out_seg.last_segment)
);
